FILE: src/cstv_pkg.sv
// Shared types and constants for the clip-to-screen viewport mapper.
// No dependencies.
package cstv_pkg;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = 13;
    localparam int MINW_W  = 16;
    localparam int NUM_W   = COORD_W + 1;
    localparam int PROD_W  = NUM_W + SIZE_W;
    localparam int QUO_W   = SIZE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_MIN_W         = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic             valid;
        logic             keep;
        logic             last;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [NUM_W-1:0] den;
    } front_t;

endpackage

FILE: src/cstv_front.sv
// Cull test and numerator/denominator setup, one register stage.
// Depends on cstv_pkg.
module cstv_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [cstv_pkg::COORD_W-1:0]   x_clip,
    input  logic [cstv_pkg::COORD_W-1:0]   y_clip,
    input  logic [cstv_pkg::COORD_W-1:0]   w_clip,
    input  logic                           last_vertex,
    input  logic [cstv_pkg::MINW_W-1:0]    min_w,
    output cstv_pkg::front_t               front
);
    import cstv_pkg::*;

    logic [NUM_W-1:0] x_ext, y_ext, w_ext, ax, ay;
    logic             keep;
    logic             valid_reg;
    front_t           front_reg, front_next;

    always_comb
    begin
        x_ext = {x_clip[COORD_W-1], x_clip};
        y_ext = {y_clip[COORD_W-1], y_clip};
        w_ext = {w_clip[COORD_W-1], w_clip};
        ax = x_clip[COORD_W-1] ? (NUM_W'(0) - x_ext) : x_ext;
        ay = y_clip[COORD_W-1] ? (NUM_W'(0) - y_ext) : y_ext;
        keep = !w_clip[COORD_W-1] && (w_clip != '0)
            && (w_clip >= COORD_W'(min_w)) && (ax <= w_ext) && (ay <= w_ext);
        front_next.valid = in_valid;
        front_next.keep  = keep;
        front_next.last  = last_vertex;
        front_next.num_x = w_ext + x_ext;
        front_next.num_y = w_ext - y_ext;
        front_next.den   = {w_clip, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= front_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
    end

    // Take the valid bit from the reset register.
    always_comb
    begin
        front       = front_reg;
        front.valid = valid_reg;
    end

endmodule

FILE: src/cstv_div_lane.sv
// One axis: registered size*num multiply, then a restoring divider that
// retires one quotient bit per stage. Depends on cstv_pkg.
module cstv_div_lane (
    input  logic                         clk,
    input  logic [cstv_pkg::SIZE_W-1:0]  size,
    input  logic [cstv_pkg::NUM_W-1:0]   num,
    input  logic [cstv_pkg::NUM_W-1:0]   den,
    output logic [cstv_pkg::QUO_W-1:0]   quo
);
    import cstv_pkg::*;

    // Quotient is below 2^QUO_W, so the product's top bits shifted down
    // already form a partial remainder smaller than den.
    logic [PROD_W-1:0] prod_reg [0:QUO_W];
    logic [NUM_W-1:0]  den_reg  [0:QUO_W];
    logic [NUM_W-1:0]  rem_reg  [0:QUO_W];
    logic [QUO_W-1:0]  quo_reg  [0:QUO_W];

    always_ff @(posedge clk)
    begin
        prod_reg[0] <= PROD_W'(size) * PROD_W'(num);
        den_reg[0]  <= den;
        rem_reg[0]  <= '0;
        quo_reg[0]  <= '0;
    end

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_step
        logic [NUM_W-1:0] rem_in;
        logic [NUM_W:0]   trial;
        logic [NUM_W:0]   diff;

        if (i == 0)
        begin : g_first
            assign rem_in = prod_reg[0][PROD_W-1:QUO_W];
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i];
        end

        always_comb
        begin
            trial = {rem_in, prod_reg[i][QUO_W-1-i]};
            diff  = trial - {1'b0, den_reg[i]};
        end

        always_ff @(posedge clk)
        begin
            prod_reg[i+1] <= prod_reg[i];
            den_reg[i+1]  <= den_reg[i];
            if (trial >= {1'b0, den_reg[i]})
            begin
                rem_reg[i+1] <= diff[NUM_W-1:0];
                quo_reg[i+1] <= quo_reg[i] | (QUO_W'(1) << (QUO_W-1-i));
            end
            else
            begin
                rem_reg[i+1] <= trial[NUM_W-1:0];
                quo_reg[i+1] <= quo_reg[i];
            end
        end
    end

    assign quo = quo_reg[QUO_W];

endmodule

FILE: src/clip_to_screen_viewport_map.sv
// Clip-to-screen viewport mapper top level.
// Depends on cstv_pkg, cstv_front and cstv_div_lane.
//
// Usage:
//   Raise start with x_clip, y_clip, w_clip (signed Q16.16) and last_vertex;
//   the vertex transfers on any clock edge with start high and busy low.
//   busy is always low, so one vertex can transfer every cycle.
//   Each vertex gives one result, shown for exactly one cycle with done high:
//   pixel_x, pixel_y, visible and end_of_list. Culled vertices show
//   visible low and zero pixels.
//   Throughput is one vertex per cycle; the pipeline has one stage for
//   the cull test, one for the size multiply, 13 for the restoring
//   divider (one quotient bit each) and one output stage.
//   Results come in input order. The receiver cannot stall; each result
//   must be taken in the cycle it is shown.
//   Registers: cfg_we writes cfg_wdata into register cfg_addr
//   (0 width, 1 height, 2 min_w); write only while no vertex is in flight.
//   Reset clears the pipeline valid bits and loads width 640, height 480
//   and min_w ceil(1e-4 in fixed point).
module clip_to_screen_viewport_map #(
    parameter int FRAC_BITS       = 16,
    parameter int SCREEN_DIM_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [cstv_pkg::COORD_W-1:0]      x_clip,
    input  logic [cstv_pkg::COORD_W-1:0]      y_clip,
    input  logic [cstv_pkg::COORD_W-1:0]      w_clip,
    input  logic                              last_vertex,
    input  logic                              cfg_we,
    input  logic [cstv_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [cstv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic                              done,
    output logic [SCREEN_DIM_BITS-1:0]        pixel_x,
    output logic [SCREEN_DIM_BITS-1:0]        pixel_y,
    output logic                              visible,
    output logic                              end_of_list
);
    import cstv_pkg::*;

    localparam int MIN_W_RESET = ((1 << FRAC_BITS) + 9999) / 10000;
    localparam int LANE_LAT    = QUO_W + 1;
    localparam logic [15:0] PIX_MAX = 16'((1 << SCREEN_DIM_BITS) - 1);

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [MINW_W-1:0] min_w_reg;

    front_t           front;
    logic [QUO_W-1:0] quo_x, quo_y;

    logic side_valid_reg [0:LANE_LAT-1];
    logic side_keep_reg  [0:LANE_LAT-1];
    logic side_last_reg  [0:LANE_LAT-1];

    logic                       done_reg, visible_reg, eol_reg;
    logic [SCREEN_DIM_BITS-1:0] px_reg, py_reg, px_next, py_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(640);
            height_reg <= SIZE_W'(480);
            min_w_reg  <= MINW_W'(MIN_W_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT: height_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_MIN_W:         min_w_reg  <= cfg_wdata[MINW_W-1:0];
                default: ;
            endcase
        end
    end

    cstv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .x_clip      (x_clip),
        .y_clip      (y_clip),
        .w_clip      (w_clip),
        .last_vertex (last_vertex),
        .min_w       (min_w_reg),
        .front       (front)
    );

    cstv_div_lane u_lane_x (
        .clk  (clk),
        .size (width_reg),
        .num  (front.num_x),
        .den  (front.den),
        .quo  (quo_x)
    );

    cstv_div_lane u_lane_y (
        .clk  (clk),
        .size (height_reg),
        .num  (front.num_y),
        .den  (front.den),
        .quo  (quo_y)
    );

    // Carry valid, keep and last alongside the multiply and divider stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
            begin
                side_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            side_valid_reg[0] <= front.valid;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                side_valid_reg[i] <= side_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_keep_reg[0] <= front.keep;
        side_last_reg[0] <= front.last;
        for (int i = 1; i < LANE_LAT; i++)
        begin
            side_keep_reg[i] <= side_keep_reg[i-1];
            side_last_reg[i] <= side_last_reg[i-1];
        end
    end

    function automatic logic [15:0] clamp_pix(input logic [SIZE_W-1:0] size,
                                              input logic [QUO_W-1:0] q);
        logic [15:0] lim;
        logic [15:0] val;
        lim = (size == '0) ? 16'd0 : 16'(size) - 16'd1;
        if (lim > PIX_MAX)
        begin
            lim = PIX_MAX;
        end
        val = 16'(q);
        return (val > lim) ? lim : val;
    endfunction

    always_comb
    begin
        logic [15:0] cx, cy;
        cx = clamp_pix(width_reg, quo_x);
        cy = clamp_pix(height_reg, quo_y);
        px_next = side_keep_reg[LANE_LAT-1] ? cx[SCREEN_DIM_BITS-1:0] : '0;
        py_next = side_keep_reg[LANE_LAT-1] ? cy[SCREEN_DIM_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side_valid_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        visible_reg <= side_keep_reg[LANE_LAT-1];
        eol_reg     <= side_last_reg[LANE_LAT-1];
    end

    assign done        = done_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign visible     = visible_reg;
    assign end_of_list = eol_reg;

endmodule

FILE: src/cstv_checker.sv
// Port-level checks for the viewport mapper, bound to the top level.
// Depends on cstv_pkg and clip_to_screen_viewport_map.
module cstv_checker #(
    parameter int SCREEN_DIM_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              done,
    input  logic [SCREEN_DIM_BITS-1:0]        pixel_x,
    input  logic [SCREEN_DIM_BITS-1:0]        pixel_y,
    input  logic                              visible
);
    import cstv_pkg::*;

    localparam int LAT = QUO_W + 3;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("transfer produced no result at fixed latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching transfer");

    a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !visible) |-> (pixel_x == '0 && pixel_y == '0))
        else $error("culled vertex with nonzero pixel");

endmodule

bind clip_to_screen_viewport_map cstv_checker #(
    .SCREEN_DIM_BITS(SCREEN_DIM_BITS)
) u_cstv_checker (.*);
